[rtl/vcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared types, constants and constant functions of the view cube picker.
// ----------------------------------------------------------------------------
package vcp_pkg;

  localparam int CUR_W      = 13;
  localparam int SCALE_W    = 16;
  localparam int ROT_W      = 16;
  localparam int PART_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_QUADS  = 18;
  localparam int NUM_FACES  = 6;
  localparam int NUM_VERTS  = 24;
  localparam int NUM_EDGES  = 72;
  localparam int NUM_GROUPS = 3;
  localparam int GROUP_SIZE = 6;
  localparam int MAX_PART   = 18;
  localparam int PIPE_DEPTH = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 2'd0,
    CFG_CENTER_Y    = 2'd1,
    CFG_SCALE_RECIP = 2'd2
  } cfg_reg_e;

  // Cube geometry at f fraction bits, rounded to nearest
  function automatic longint half_q(int f);
    return (longint'(68) * (longint'(1) << f) + 50) / 100;
  endfunction

  function automatic longint inner_q(int f);
    return (longint'(58) * (longint'(1) << f) + 50) / 100;
  endfunction

  function automatic longint bound_q(int f);
    return (longint'(11832) * (longint'(1) << f) + 5000) / 10000;
  endfunction

  function automatic longint eps_q(int f);
    return ((longint'(1) << (2 * f)) + 50000) / 100000;
  endfunction

  // Vertex i of quad n as {h_axis[1:0], signs[2:0]}; sign bit j set means
  // positive along axis j, and h_axis carries the half size, the others inner.
  function automatic logic [4:0] quad_vtx(int n, int i);
    int axis;
    int au;
    int av;
    int bev;
    int pair;
    int a;
    int b;
    int c;
    logic [2:0] sg;
    logic [1:0] k;
    sg = 3'b000;
    if (n < NUM_FACES) begin
      axis = n / 2;
      au = (axis + 1) % 3;
      av = (axis + 2) % 3;
      sg[axis] = (n % 2) == 1;
      sg[au] = (i == 1) || (i == 2);
      sg[av] = (i == 2) || (i == 3);
      k = 2'(axis);
    end else begin
      bev = n - NUM_FACES;
      pair = bev / 4;
      a = (pair == 2) ? 1 : 0;
      b = (pair == 0) ? 1 : 2;
      c = 3 - a - b;
      sg[a] = ((bev / 2) % 2) == 1;
      sg[b] = (bev % 2) == 1;
      sg[c] = (i >= 2);
      k = ((i == 0) || (i == 3)) ? 2'(a) : 2'(b);
    end
    return {k, sg};
  endfunction

  function automatic int vtx_index(logic [4:0] v);
    return int'(v[4:3]) * 8 + int'(v[2:0]);
  endfunction

endpackage

[rtl/vcp_project.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcp_project
// Cursor scaling, rotation products, vertex projection and quad depths.
// Two register stages.
// ----------------------------------------------------------------------------
module vcp_project import vcp_pkg::*; #(
  parameter int F = 14
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [CUR_W-1:0]        cursor_x_i,
  input  logic [CUR_W-1:0]        cursor_y_i,
  input  logic [CUR_W-1:0]        center_x_i,
  input  logic [CUR_W-1:0]        center_y_i,
  input  logic [SCALE_W-1:0]      scale_i,
  input  logic signed [ROT_W-1:0] rot_i [3][3],
  output logic                    inbox_o,
  output logic signed [F+1:0]     px_o,
  output logic signed [F+1:0]     py_o,
  output logic signed [2*F+3:0]   sqx_o,
  output logic signed [2*F+3:0]   sqy_o,
  output logic signed [F+4:0]     qx_o [NUM_VERTS],
  output logic signed [F+4:0]     qy_o [NUM_VERTS],
  output logic signed [F+20:0]    depth_o [NUM_QUADS]
);

  localparam int PROD_W = 31;
  localparam int PW = F + 15;
  localparam int HW = F + 17;
  localparam int SW = F + 19;
  localparam int QW = F + 5;
  localparam int DW = F + 21;

  localparam logic signed [F:0]    HALF_C   = (F+1)'(half_q(F));
  localparam logic signed [F:0]    INNER_C  = (F+1)'(inner_q(F));
  localparam logic signed [PW-1:0] BOUND_C  = PW'(bound_q(F));
  localparam logic signed [PW-1:0] NBOUND_C = PW'(-bound_q(F));
  localparam logic signed [SW-1:0] PROJ_RND = SW'(8192);

  // Stage 1: scaled cursor and rotation products
  logic signed [PW-1:0] p_d [2];
  logic signed [PW-1:0] p_q [2];
  logic signed [HW-1:0] hr_q [3][3];
  logic signed [HW-1:0] ir_q [3][3];
  logic signed [ROT_W-1:0] rz_q [3];

  logic [CUR_W-1:0] cur [2];
  logic [CUR_W-1:0] ctr [2];
  assign cur[0] = cursor_x_i;
  assign cur[1] = cursor_y_i;
  assign ctr[0] = center_x_i;
  assign ctr[1] = center_y_i;

  for (genvar ax = 0; ax < 2; ax++) begin : g_cursor
    logic signed [CUR_W:0]    dif;
    logic signed [PROD_W-1:0] prod;
    assign dif  = $signed({1'b0, cur[ax]}) - $signed({1'b0, ctr[ax]});
    assign prod = dif * $signed({1'b0, scale_i});
    if (F < 16) begin : g_round
      localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< (15 - F);
      logic signed [PROD_W-1:0] rsh;
      assign rsh = (prod + RND) >>> (16 - F);
      assign p_d[ax] = rsh[PW-1:0];
    end else begin : g_exact
      assign p_d[ax] = PW'(prod) <<< (F - 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          hr_q[r][c] <= HALF_C * rot_i[r][c];
          ir_q[r][c] <= INNER_C * rot_i[r][c];
        end
        rz_q[r] <= rot_i[r][2];
      end
      p_q[0] <= p_d[0];
      p_q[1] <= p_d[1];
    end
  end

  // Stage 2: bound box, squares, projected vertices, depths
  logic signed [F+1:0] pxc;
  logic signed [F+1:0] pyc;
  logic signed [QW-1:0] qx_d [NUM_VERTS];
  logic signed [QW-1:0] qy_d [NUM_VERTS];
  logic signed [DW-1:0] depth_d [NUM_QUADS];
  logic inbox_d;

  assign pxc = p_q[0][F+1:0];
  assign pyc = p_q[1][F+1:0];
  assign inbox_d = !(p_q[0] > BOUND_C || p_q[0] < NBOUND_C ||
                     p_q[1] > BOUND_C || p_q[1] < NBOUND_C);

  for (genvar v = 0; v < NUM_VERTS; v++) begin : g_vert
    localparam int K = v / 8;
    localparam logic [2:0] SG = 3'(v % 8);
    for (genvar c = 0; c < 2; c++) begin : g_col
      logic signed [SW-1:0] t [3];
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] sr;
      for (genvar j = 0; j < 3; j++) begin : g_term
        logic signed [SW-1:0] m;
        assign m = (j == K) ? SW'(hr_q[j][c]) : SW'(ir_q[j][c]);
        assign t[j] = SG[j] ? m : -m;
      end
      assign s  = t[0] + t[1] + t[2];
      assign sr = (s + PROJ_RND) >>> 14;
      if (c == 0) begin : g_x
        assign qx_d[v] = sr[QW-1:0];
      end else begin : g_y
        assign qy_d[v] = sr[QW-1:0];
      end
    end
  end

  for (genvar n = 0; n < NUM_QUADS; n++) begin : g_depth
    if (n < NUM_FACES) begin : g_face
      localparam int A = n / 2;
      logic signed [DW-1:0] rz;
      assign rz = DW'(rz_q[A]) <<< (F + 2);
      assign depth_d[n] = ((n % 2) == 1) ? rz : -rz;
    end else begin : g_bevel
      localparam logic [4:0] V0 = quad_vtx(n, 0);
      localparam logic [4:0] V1 = quad_vtx(n, 1);
      localparam int A = int'(V0[4:3]);
      localparam int B = int'(V1[4:3]);
      logic signed [DW-1:0] ta;
      logic signed [DW-1:0] tb;
      assign ta = DW'(hr_q[A][2]) + DW'(ir_q[A][2]);
      assign tb = DW'(hr_q[B][2]) + DW'(ir_q[B][2]);
      assign depth_d[n] = ((V0[A] ? ta : -ta) + (V0[B] ? tb : -tb)) <<< 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inbox_o <= inbox_d;
      px_o    <= pxc;
      py_o    <= pyc;
      sqx_o   <= pxc * pxc;
      sqy_o   <= pyc * pyc;
      for (int v = 0; v < NUM_VERTS; v++) begin
        qx_o[v] <= qx_d[v];
        qy_o[v] <= qy_d[v];
      end
      for (int n = 0; n < NUM_QUADS; n++) begin
        depth_o[n] <= depth_d[n];
      end
    end
  end

endmodule

[rtl/vcp_edge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcp_edge
// Radius check and edge cross products of all quads. Two register stages.
// ----------------------------------------------------------------------------
module vcp_edge import vcp_pkg::*; #(
  parameter int F = 14
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  inbox_i,
  input  logic signed [F+1:0]   px_i,
  input  logic signed [F+1:0]   py_i,
  input  logic signed [2*F+3:0] sqx_i,
  input  logic signed [2*F+3:0] sqy_i,
  input  logic signed [F+4:0]   qx_i [NUM_VERTS],
  input  logic signed [F+4:0]   qy_i [NUM_VERTS],
  input  logic signed [F+20:0]  depth_i [NUM_QUADS],
  output logic                  in_bound_o,
  output logic [NUM_QUADS-1:0]  hit_o,
  output logic signed [F+20:0]  depth_o [NUM_QUADS]
);

  localparam int EW  = F + 6;
  localparam int MW  = 2 * F + 12;
  localparam int CRW = 2 * F + 13;
  localparam int SQW = 2 * F + 5;

  localparam logic [SQW-1:0]       BOUND_SQ = SQW'(bound_q(F) * bound_q(F));
  localparam logic signed [CRW-1:0] EPS_C   = CRW'(eps_q(F));
  localparam logic signed [CRW-1:0] NEPS_C  = CRW'(-eps_q(F));

  // Stage 3: products of every edge
  logic signed [MW-1:0] m1_q [NUM_EDGES];
  logic signed [MW-1:0] m2_q [NUM_EDGES];
  logic signed [MW-1:0] m1_d [NUM_EDGES];
  logic signed [MW-1:0] m2_d [NUM_EDGES];
  logic signed [F+20:0] depth_q [NUM_QUADS];
  logic in_bound_q;
  logic [SQW-1:0] sq_sum;

  assign sq_sum = SQW'(sqx_i[2*F+3:0]) + SQW'(sqy_i[2*F+3:0]);

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    localparam int VA = vtx_index(quad_vtx(e / 4, e % 4));
    localparam int VB = vtx_index(quad_vtx(e / 4, (e + 1) % 4));
    logic signed [EW-1:0] dxe;
    logic signed [EW-1:0] dye;
    logic signed [EW-1:0] dxp;
    logic signed [EW-1:0] dyp;
    assign dxe = EW'(qx_i[VB]) - EW'(qx_i[VA]);
    assign dye = EW'(qy_i[VB]) - EW'(qy_i[VA]);
    assign dxp = EW'(px_i) - EW'(qx_i[VA]);
    assign dyp = EW'(py_i) - EW'(qy_i[VA]);
    assign m1_d[e] = dxe * dyp;
    assign m2_d[e] = dye * dxp;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_bound_q <= inbox_i && (sq_sum <= BOUND_SQ);
      for (int e = 0; e < NUM_EDGES; e++) begin
        m1_q[e] <= m1_d[e];
        m2_q[e] <= m2_d[e];
      end
      for (int n = 0; n < NUM_QUADS; n++) begin
        depth_q[n] <= depth_i[n];
      end
    end
  end

  // Stage 4: sign of each cross product against epsilon
  logic [NUM_QUADS-1:0] hit_d;

  for (genvar n = 0; n < NUM_QUADS; n++) begin : g_quad
    logic [3:0] neg;
    logic [3:0] pos;
    for (genvar i = 0; i < 4; i++) begin : g_side
      logic signed [CRW-1:0] cr;
      assign cr = CRW'(m1_q[n*4+i]) - CRW'(m2_q[n*4+i]);
      assign neg[i] = cr < NEPS_C;
      assign pos[i] = cr > EPS_C;
    end
    assign hit_d[n] = !((|neg) && (|pos));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_bound_o <= in_bound_q;
      hit_o      <= hit_d;
      for (int n = 0; n < NUM_QUADS; n++) begin
        depth_o[n] <= depth_q[n];
      end
    end
  end

endmodule

[rtl/vcp_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcp_select
// Deepest hit quad, earlier quad on a tie. Group pass, then final pass.
// ----------------------------------------------------------------------------
module vcp_select import vcp_pkg::*; #(
  parameter int F = 14
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 in_bound_i,
  input  logic [NUM_QUADS-1:0] hit_i,
  input  logic signed [F+20:0] depth_i [NUM_QUADS],
  output logic [PART_W-1:0]    part_o
);

  logic                 g_have_d [NUM_GROUPS];
  logic signed [F+20:0] g_best_d [NUM_GROUPS];
  logic [PART_W-1:0]    g_code_d [NUM_GROUPS];
  logic                 g_have_q [NUM_GROUPS];
  logic signed [F+20:0] g_best_q [NUM_GROUPS];
  logic [PART_W-1:0]    g_code_q [NUM_GROUPS];
  logic                 in_bound_q;

  // Stage 5: best within each group of six, in test order
  always_comb begin
    int n;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      g_have_d[g] = 1'b0;
      g_best_d[g] = '0;
      g_code_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        n = g * GROUP_SIZE + j;
        if (hit_i[n] && (!g_have_d[g] || depth_i[n] > g_best_d[g])) begin
          g_have_d[g] = 1'b1;
          g_best_d[g] = depth_i[n];
          g_code_d[g] = PART_W'(n + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_bound_q <= in_bound_i;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        g_have_q[g] <= g_have_d[g];
        g_best_q[g] <= g_best_d[g];
        g_code_q[g] <= g_code_d[g];
      end
    end
  end

  // Stage 6: merge the groups; a later group only wins on a strictly deeper hit
  logic [PART_W-1:0] part_d;

  always_comb begin
    logic                 have;
    logic signed [F+20:0] best;
    logic [PART_W-1:0]    code;
    have = 1'b0;
    best = '0;
    code = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (g_have_q[g] && (!have || g_best_q[g] > best)) begin
        have = 1'b1;
        best = g_best_q[g];
        code = g_code_q[g];
      end
    end
    part_d = (in_bound_q && have) ? code : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_o <= part_d;
    end
  end

endmodule

[rtl/view_cube_pick.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// view_cube_pick
// Picks the face or bevel of a view cube under the cursor.
// ----------------------------------------------------------------------------
// Input channel: cursor position and 3x3 view rotation, one transaction per
// query, taken when in_valid_i is high and in_stall_o is low.
// Output channel: one hit_part_o per query (0 none, 1-6 face, 7-18 bevel),
// in query order, taken when out_valid_o is high and out_stall_i is low.
// Configuration: cfg_index_i selects center x (0), center y (1) or the scale
// reciprocal (2); a transaction completes on cfg_valid_i, cfg_ready_o is
// always high. Write only while no query is in flight.
// A new query can be taken every cycle while in_stall_o is low. The
// six-stage pipeline (scale, project, cross products, edge signs, group
// select, final select) advances as one.
// While the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o is raised; nothing is dropped or repeated.
// Reset clears all valid bits and loads center 0,0 and scale reciprocal 1638.
// ----------------------------------------------------------------------------
module view_cube_pick import vcp_pkg::*; #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CUR_W-1:0]        cursor_x_i,
  input  logic [CUR_W-1:0]        cursor_y_i,
  input  logic signed [ROT_W-1:0] rot_00_i,
  input  logic signed [ROT_W-1:0] rot_01_i,
  input  logic signed [ROT_W-1:0] rot_02_i,
  input  logic signed [ROT_W-1:0] rot_10_i,
  input  logic signed [ROT_W-1:0] rot_11_i,
  input  logic signed [ROT_W-1:0] rot_12_i,
  input  logic signed [ROT_W-1:0] rot_20_i,
  input  logic signed [ROT_W-1:0] rot_21_i,
  input  logic signed [ROT_W-1:0] rot_22_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PART_W-1:0]       hit_part_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int F = COORD_FRAC_BITS;

  // Configuration registers
  logic [CUR_W-1:0]   center_x_q;
  logic [CUR_W-1:0]   center_y_q;
  logic [SCALE_W-1:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      scale_q    <= SCALE_W'(1638);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CENTER_X:    center_x_q <= cfg_data_i[CUR_W-1:0];
        CFG_CENTER_Y:    center_y_q <= cfg_data_i[CUR_W-1:0];
        CFG_SCALE_RECIP: scale_q    <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: advance unless the finished result is held
  logic [PIPE_DEPTH-1:0] valid_q;
  logic [PIPE_DEPTH-1:0] valid_d;
  logic adv;

  assign adv        = !valid_q[PIPE_DEPTH-1] || !out_stall_i;
  assign in_stall_o = !adv;
  assign valid_d    = {valid_q[PIPE_DEPTH-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q[PIPE_DEPTH-1];

  logic signed [ROT_W-1:0] rot [3][3];
  assign rot[0][0] = rot_00_i;
  assign rot[0][1] = rot_01_i;
  assign rot[0][2] = rot_02_i;
  assign rot[1][0] = rot_10_i;
  assign rot[1][1] = rot_11_i;
  assign rot[1][2] = rot_12_i;
  assign rot[2][0] = rot_20_i;
  assign rot[2][1] = rot_21_i;
  assign rot[2][2] = rot_22_i;

  logic                   inbox;
  logic signed [F+1:0]    px;
  logic signed [F+1:0]    py;
  logic signed [2*F+3:0]  sqx;
  logic signed [2*F+3:0]  sqy;
  logic signed [F+4:0]    qx [NUM_VERTS];
  logic signed [F+4:0]    qy [NUM_VERTS];
  logic signed [F+20:0]   depth_p [NUM_QUADS];
  logic signed [F+20:0]   depth_e [NUM_QUADS];
  logic                   in_bound;
  logic [NUM_QUADS-1:0]   hit;

  vcp_project #(.F(F)) u_project (
    .clk_i      (clk_i),
    .en_i       (adv),
    .cursor_x_i (cursor_x_i),
    .cursor_y_i (cursor_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .scale_i    (scale_q),
    .rot_i      (rot),
    .inbox_o    (inbox),
    .px_o       (px),
    .py_o       (py),
    .sqx_o      (sqx),
    .sqy_o      (sqy),
    .qx_o       (qx),
    .qy_o       (qy),
    .depth_o    (depth_p)
  );

  vcp_edge #(.F(F)) u_edge (
    .clk_i      (clk_i),
    .en_i       (adv),
    .inbox_i    (inbox),
    .px_i       (px),
    .py_i       (py),
    .sqx_i      (sqx),
    .sqy_i      (sqy),
    .qx_i       (qx),
    .qy_i       (qy),
    .depth_i    (depth_p),
    .in_bound_o (in_bound),
    .hit_o      (hit),
    .depth_o    (depth_e)
  );

  vcp_select #(.F(F)) u_select (
    .clk_i      (clk_i),
    .en_i       (adv),
    .in_bound_i (in_bound),
    .hit_i      (hit),
    .depth_i    (depth_e),
    .part_o     (hit_part_o)
  );

  a_part_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hit_part_o <= PART_W'(MAX_PART))
    else $error("hit part code out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(valid_q))
    else $error("pipeline moved while stalled");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !valid_q[PIPE_DEPTH-2] |=> !out_valid_o)
    else $error("result repeated after delivery");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the view cube picker.
// Drives cursor and rotation queries under random gaps and output stalls,
// predicts each hit part with an integer model of the cube geometry and
// compares every result in order. Register settings are swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import vcp_pkg::*;

  localparam int           FRAC    = 14;
  localparam longint       ONE     = 64'sd1 <<< FRAC;
  localparam longint       HALF    = (68 * ONE + 50) / 100;
  localparam longint       INNER   = (58 * ONE + 50) / 100;
  localparam longint       RADIUS  = (11832 * ONE + 5000) / 10000;
  localparam longint       EPSILON = ((64'sd1 <<< (2 * FRAC)) + 50000) / 100000;
  localparam int           LIMIT   = 600000;

  typedef struct {
    logic [CUR_W-1:0]        cx;
    logic [CUR_W-1:0]        cy;
    logic signed [ROT_W-1:0] m [9];
  } cube_query_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic [CUR_W-1:0] cursor_x = '0;
  logic [CUR_W-1:0] cursor_y = '0;
  logic signed [ROT_W-1:0] rot [9] = '{default: '0};
  logic in_stall, out_valid, cfg_ready;
  logic [PART_W-1:0] hit_part;

  logic [CUR_W-1:0] center_x = '0;
  logic [CUR_W-1:0] center_y = '0;
  logic [SCALE_W-1:0] scale_recip = 16'd1638;
  logic [PART_W-1:0] expected_parts [$];
  int errors = 0;
  int cycles = 0;
  bit hold_request = 1'b0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  view_cube_pick uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cursor_x_i(cursor_x), .cursor_y_i(cursor_y),
    .rot_00_i(rot[0]), .rot_01_i(rot[1]), .rot_02_i(rot[2]),
    .rot_10_i(rot[3]), .rot_11_i(rot[4]), .rot_12_i(rot[5]),
    .rot_20_i(rot[6]), .rot_21_i(rot[7]), .rot_22_i(rot[8]),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .hit_part_o(hit_part),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Project a quad to Q.F screen space; return the exact sum of vertex depths.
  function automatic longint project_quad(input longint r [3][3], input longint v [4][3],
                                          output longint q [4][2]);
    longint dsum;
    longint s;
    dsum = 0;
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 2; c++) begin
        s = v[i][0] * r[0][c] + v[i][1] * r[1][c] + v[i][2] * r[2][c];
        q[i][c] = (s + 8192) >>> 14;
      end
      dsum += v[i][0] * r[0][2] + v[i][1] * r[1][2] + v[i][2] * r[2][2];
    end
    return dsum;
  endfunction

  function automatic bit covers(longint px, longint py, longint q [4][2]);
    bit neg;
    bit pos;
    longint cr;
    neg = 0;
    pos = 0;
    for (int i = 0; i < 4; i++) begin
      cr = (q[(i + 1) % 4][0] - q[i][0]) * (py - q[i][1])
         - (q[(i + 1) % 4][1] - q[i][1]) * (px - q[i][0]);
      if (cr < -EPSILON) neg = 1;
      if (cr > EPSILON) pos = 1;
    end
    return !(neg && pos);
  endfunction

  function automatic longint to_cube(logic [CUR_W-1:0] cur, logic [CUR_W-1:0] ctr);
    longint prod;
    prod = (longint'(cur) - longint'(ctr)) * longint'(scale_recip);
    return (prod + 2) >>> 2;
  endfunction

  function automatic logic [PART_W-1:0] pick_part(cube_query_t qy);
    longint r [3][3];
    longint vtx [4][3];
    longint pq [4][2];
    longint px, py, best, depth;
    int cu [4];
    int cv [4];
    int au, av, c, bev;
    bit have;
    logic [PART_W-1:0] part;
    cu = '{-1, 1, 1, -1};
    cv = '{-1, -1, 1, 1};
    px = to_cube(qy.cx, center_x);
    py = to_cube(qy.cy, center_y);
    for (int k = 0; k < 9; k++) r[k / 3][k % 3] = longint'(qy.m[k]);
    if (px > RADIUS || px < -RADIUS || py > RADIUS || py < -RADIUS) return '0;
    if (px * px + py * py > RADIUS * RADIUS) return '0;
    have = 0;
    best = 0;
    part = '0;
    for (int axis = 0; axis < 3; axis++) begin
      au = (axis + 1) % 3;
      av = (axis + 2) % 3;
      for (int ps = 0; ps < 2; ps++) begin
        for (int i = 0; i < 4; i++) begin
          vtx[i][axis] = ps ? HALF : -HALF;
          vtx[i][au] = cu[i] * INNER;
          vtx[i][av] = cv[i] * INNER;
        end
        void'(project_quad(r, vtx, pq));
        depth = r[axis][2] * (ps ? 1 : -1) * 4 * ONE;
        if ((!have || depth > best) && covers(px, py, pq)) begin
          have = 1;
          best = depth;
          part = PART_W'(axis * 2 + ps + 1);
        end
      end
    end
    bev = 0;
    for (int a = 0; a < 3; a++) begin
      for (int b = a + 1; b < 3; b++) begin
        c = 3 - a - b;
        for (int sa = -1; sa <= 1; sa += 2) begin
          for (int sb = -1; sb <= 1; sb += 2) begin
            vtx[0][a] = sa * HALF;  vtx[0][b] = sb * INNER; vtx[0][c] = -INNER;
            vtx[1][a] = sa * INNER; vtx[1][b] = sb * HALF;  vtx[1][c] = -INNER;
            vtx[2][a] = sa * INNER; vtx[2][b] = sb * HALF;  vtx[2][c] = INNER;
            vtx[3][a] = sa * HALF;  vtx[3][b] = sb * INNER; vtx[3][c] = INNER;
            depth = project_quad(r, vtx, pq);
            if ((!have || depth > best) && covers(px, py, pq)) begin
              have = 1;
              best = depth;
              part = PART_W'(bev + 7);
            end
            bev++;
          end
        end
      end
    end
    return part;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CENTER_X: center_x = value[CUR_W-1:0];
      CFG_CENTER_Y: center_y = value[CUR_W-1:0];
      default:      scale_recip = value;
    endcase
    @(posedge clk);
  endtask

  // Drive one query, wait for its transaction, then draw the gap before the next.
  task automatic send_query(cube_query_t qy);
    int gap;
    in_valid <= 1'b1;
    cursor_x <= qy.cx;
    cursor_y <= qy.cy;
    rot <= qy.m;
    do @(posedge clk); while (in_stall);
    expected_parts.push_back(pick_part(qy));
    gap = quiet_tx ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_parts.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  function automatic logic signed [ROT_W-1:0] q14(real x);
    return ROT_W'($rtoi(x * 16384.0 + ((x >= 0.0) ? 0.5 : -0.5)));
  endfunction

  // Mostly true rotations, some axis-aligned views and some raw noise.
  function automatic cube_query_t random_query();
    cube_query_t qy;
    real a, b, g, ca, sa, cb, sb, cg, sg, span;
    int kind, off;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      a = $urandom_range(0, 62831) / 10000.0;
      b = $urandom_range(0, 62831) / 10000.0;
      g = $urandom_range(0, 62831) / 10000.0;
      ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cg = $cos(g); sg = $sin(g);
      qy.m[0] = q14(ca * cb);  qy.m[1] = q14(ca * sb * sg - sa * cg);
      qy.m[2] = q14(ca * sb * cg + sa * sg);
      qy.m[3] = q14(sa * cb);  qy.m[4] = q14(sa * sb * sg + ca * cg);
      qy.m[5] = q14(sa * sb * cg - ca * sg);
      qy.m[6] = q14(-sb);      qy.m[7] = q14(cb * sg);  qy.m[8] = q14(cb * cg);
    end else if (kind < 17) begin
      qy.m = '{default: '0};
      off = $urandom_range(0, 2);
      for (int r = 0; r < 3; r++)
        qy.m[r * 3 + (r + off) % 3] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    end else begin
      foreach (qy.m[k]) qy.m[k] = $urandom_range(0, 65535);
    end
    if ($urandom_range(0, 9) == 0) begin
      qy.cx = $urandom_range(0, 8191);
      qy.cy = $urandom_range(0, 8191);
    end else begin
      span = (scale_recip == 0) ? 100.0 : 1.3 * 65536.0 / scale_recip;
      if (span > 4000.0) span = 4000.0;
      off = $rtoi(span) + 1;
      qy.cx = CUR_W'(int'(center_x) + $urandom_range(0, 2 * off) - off);
      qy.cy = CUR_W'(int'(center_y) + $urandom_range(0, 2 * off) - off);
    end
    return qy;
  endfunction

  task automatic test_directed();
    cube_query_t qy;
    logic signed [ROT_W-1:0] ends [4];
    ends = '{16'sd16384, -16'sd16384, -16'sd32768, 16'sd32767};
    // identity and axis views at small offsets from the centre
    for (int k = 0; k < 6; k++) begin
      qy.m = '{default: '0};
      for (int r = 0; r < 3; r++) qy.m[r * 3 + (r + k / 2) % 3] = (k % 2) ? -16'sd16384 : 16'sd16384;
      qy.cx = center_x + CUR_W'(k);
      qy.cy = center_y + CUR_W'(3 * k);
      send_query(qy);
    end
    foreach (ends[k]) begin
      qy.m = '{default: ends[k]};
      qy.cx = center_x;
      qy.cy = center_y;
      send_query(qy);
    end
    // far cursor, outside the bounding radius
    qy.m = '{default: 16'sd9459};
    qy.cx = 13'h1FFF;
    qy.cy = 13'h1FFF;
    send_query(qy);
    qy.cx = center_x + 13'd40;
    qy.cy = center_y + 13'd40;
    send_query(qy);
    // bevel-on views: 45 degrees about each axis
    for (int k = 0; k < 3; k++) begin
      qy.m = '{default: '0};
      qy.m[k * 4] = 16'sd16384;
      qy.m[((k + 1) % 3) * 4] = 16'sd11585;
      qy.m[((k + 2) % 3) * 4] = 16'sd11585;
      qy.m[((k + 1) % 3) * 3 + (k + 2) % 3] = 16'sd11585;
      qy.m[((k + 2) % 3) * 3 + (k + 1) % 3] = -16'sd11585;
      qy.cx = center_x;
      qy.cy = center_y;
      send_query(qy);
    end
    drain();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 97 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      send_query(random_query());
    end
    quiet_tx = 0;
    quiet_rx = 0;
    drain();
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    quiet_tx = 1'b1;
    for (int n = 0; n < 40; n++) send_query(random_query());
    quiet_tx = 1'b0;
    drain();
  endtask

  task automatic test_config_sweep();
    logic [CUR_W-1:0] cxs [5];
    logic [CUR_W-1:0] cys [5];
    logic [SCALE_W-1:0] srs [5];
    cxs = '{13'd4096, 13'd0, 13'h1FFF, 13'd0, 13'd1234};
    cys = '{13'd4096, 13'h1FFF, 13'd0, 13'd0, 13'd6000};
    srs = '{16'd1638, 16'd65535, 16'd1, 16'd0, 16'd700};
    foreach (srs[k]) begin
      write_reg(CFG_CENTER_X, {3'b000, cxs[k]});
      write_reg(CFG_CENTER_Y, {3'b000, cys[k]});
      write_reg(CFG_SCALE_RECIP, srs[k]);
      test_directed();
      test_random((k == 3) ? 60 : 275);
    end
  endtask

  // Receiver: per result draw a stall length; honor a long hold when asked.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = quiet_rx ? 0 : $urandom_range(0, 17);
      if (hold_request) begin
        n = 300;
        hold_request = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_parts.size() == 0) begin
        report_mismatch("unexpected result, hit_part", hit_part, -1);
      end else begin
        if (hit_part !== expected_parts[0])
          report_mismatch("hit_part", hit_part, expected_parts[0]);
        void'(expected_parts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(60);
    test_backpressure();
    test_config_sweep();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (errors == 0 && expected_parts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/vcp_pkg.sv
rtl/vcp_project.sv
rtl/vcp_edge.sv
rtl/vcp_select.sv
rtl/view_cube_pick.sv
tb/tb_top.sv
